/* src/stirs_pkg.sv */
// shared constants, types and key normalization for the slot table
package stirs_pkg;

  localparam int SLOTS     = 32;
  localparam int KEY_CHARS = 8;
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CFG_W     = 6;
  localparam int POS_W     = 6;
  localparam int IDX_W     = 5;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SORT   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;
    logic lt;
    logic zero;
  } cmp_res_t;

  // keep the leading KEY_CHARS bytes, clear everything after the first zero byte
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic             live;
    logic [7:0]       byte_v;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      byte_v = raw[KEY_W-1-8*b -: 8];
      if (byte_v == 8'd0 || b >= KEY_CHARS) begin
        live = 1'b0;
      end
      if (live) begin
        res[KEY_W-1-8*b -: 8] = byte_v;
      end
    end
    return res;
  endfunction

endpackage

/* src/stirs_ram.sv */
// generic single write, single read ram with registered read data
module stirs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/stirs_cmp.sv */
// shared 64-bit compare unit: equality, unsigned less-than, zero test
module stirs_cmp
  import stirs_pkg::*;
(
  input  logic [KEY_W-1:0] a,
  input  logic [KEY_W-1:0] b,
  output cmp_res_t         res
);

  always_comb begin
    res.eq   = (a == b);
    res.lt   = (a < b);
    res.zero = (a == '0);
  end

endmodule

/* src/slot_table_insert_remove_sort_top.sv */
// slot table top: command sequencer over one slot ram and a shared compare unit
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------------
//   command  | in_kind, in_key, in_position            | taken when start && !busy
//   result   | out_ok, out_slot_index, out_read_key    | out_valid strobe, one cycle
//   config   | cfg_wdata                               | written when cfg_we is high
//
// the ram read for the next slot is issued while the current one is compared, one slot a cycle.
// add scans from slot 0 for a duplicate or a free slot; remove and read each touch one slot;
// a rejected position is answered from idle; sort first scans for a free slot, else selection sorts.
// reset marks every slot free through per-slot valid bits; no clearing pass is needed.
// busy is high while the sequencer is out of idle and is low again in the strobe cycle; the receiver cannot stall.
module slot_table_insert_remove_sort_top
  import stirs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [POS_W-1:0]   in_position,
  output logic               out_valid,
  output logic               out_ok,
  output logic [IDX_W-1:0]   out_slot_index,
  output logic [KEY_W-1:0]   out_read_key,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_REM,
    S_RD_RD,
    S_RD_CHK,
    S_FULL_RD,
    S_FULL_CHK,
    S_SRT_RDI,
    S_SRT_LDI,
    S_SRT_RDJ,
    S_SRT_CMP,
    S_SRT_WRI
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_slots_r;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    a_r, a_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SLOTS-1:0]    valid_r;
  logic                rvalid_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]    ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [KEY_W-1:0]    cmp_b;
  cmp_res_t            cmp;
  logic [CNT_W-1:0]    n_in;
  logic [CNT_W-1:0]    i_inc;

  stirs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a slot never written since reset reads as free
  assign rd_key = rvalid_r ? ram_rdata : '0;
  assign cmp_b  = (state_r == S_SRT_CMP) ? a_r : key_r;

  stirs_cmp u_cmp (
    .a   (rd_key),
    .b   (cmp_b),
    .res (cmp)
  );

  assign n_in  = (int'(cfg_slots_r) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(cfg_slots_r);
  assign i_inc = i_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    a_nxt         = a_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_key_nxt   = out_key_r;
    ram_we        = 1'b0;
    ram_waddr     = i_r[SLOT_W-1:0];
    ram_wdata     = key_r;
    ram_raddr     = i_r[SLOT_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt     = normalize_key(in_key);
          pos_nxt     = in_position;
          n_nxt       = n_in;
          i_nxt       = '0;
          out_ok_nxt  = 1'b0;
          out_idx_nxt = '0;
          out_key_nxt = '0;
          case (kind_t'(in_kind))
            KIND_ADD: begin
              if (n_in == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end
            KIND_REMOVE: begin
              if (in_position != '0 && int'(in_position) < int'(n_in)) begin
                state_nxt = S_REM;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            KIND_SORT: begin
              if (n_in == '0) begin
                out_ok_nxt    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_FULL_RD;
              end
            end
            KIND_READ: begin
              if (in_position != '0 && int'(in_position) <= int'(n_in)) begin
                state_nxt = S_RD_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_ADD_RD: begin
        state_nxt = S_ADD_CHK;
      end

      S_ADD_CHK: begin
        if (cmp.eq) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cmp.zero) begin
          ram_we        = 1'b1;
          out_ok_nxt    = 1'b1;
          out_idx_nxt   = IDX_W'(i_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (i_inc == n_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          i_nxt     = i_inc;
          ram_raddr = i_inc[SLOT_W-1:0];
          state_nxt = S_ADD_CHK;
        end
      end

      S_REM: begin
        ram_we        = 1'b1;
        ram_waddr     = SLOT_W'(pos_r - POS_W'(1));
        ram_wdata     = '0;
        out_ok_nxt    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RD_RD: begin
        ram_raddr = SLOT_W'(pos_r - POS_W'(1));
        state_nxt = S_RD_CHK;
      end

      S_RD_CHK: begin
        out_ok_nxt    = 1'b1;
        out_key_nxt   = rd_key;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_FULL_RD: begin
        state_nxt = S_FULL_CHK;
      end

      S_FULL_CHK: begin
        if (cmp.zero) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (i_inc == n_r) begin
          if (n_r == CNT_W'(1)) begin
            out_ok_nxt    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            i_nxt     = '0;
            state_nxt = S_SRT_RDI;
          end
        end else begin
          i_nxt     = i_inc;
          ram_raddr = i_inc[SLOT_W-1:0];
          state_nxt = S_FULL_CHK;
        end
      end

      // selection pass: a_r carries slot i, swapped with each slot j, from the top down, that holds a smaller key
      S_SRT_RDI: begin
        state_nxt = S_SRT_LDI;
      end

      S_SRT_LDI: begin
        a_nxt     = rd_key;
        j_nxt     = n_r - CNT_W'(1);
        ram_raddr = SLOT_W'(n_r - CNT_W'(1));
        state_nxt = S_SRT_CMP;
      end

      S_SRT_RDJ: begin
        ram_raddr = j_r[SLOT_W-1:0];
        state_nxt = S_SRT_CMP;
      end

      S_SRT_CMP: begin
        if (cmp.lt) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[SLOT_W-1:0];
          ram_wdata = a_r;
          a_nxt     = rd_key;
        end
        if (j_r - CNT_W'(1) == i_r) begin
          state_nxt = S_SRT_WRI;
        end else begin
          j_nxt     = j_r - CNT_W'(1);
          ram_raddr = SLOT_W'(j_r - CNT_W'(1));
          state_nxt = S_SRT_CMP;
        end
      end

      S_SRT_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[SLOT_W-1:0];
        ram_wdata = a_r;
        if (i_inc + CNT_W'(1) >= n_r) begin
          out_ok_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          i_nxt     = i_inc;
          ram_raddr = i_inc[SLOT_W-1:0];
          state_nxt = S_SRT_LDI;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_slots_r <= CFG_W'(SLOTS);
      valid_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= valid_r[ram_raddr];
      if (cfg_we) begin
        cfg_slots_r <= cfg_wdata;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    key_r     <= key_nxt;
    a_r       <= a_nxt;
    pos_r     <= pos_nxt;
    out_ok_r  <= out_ok_nxt;
    out_idx_r <= out_idx_nxt;
    out_key_r <= out_key_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_slot_index = out_idx_r;
  assign out_read_key   = out_key_r;

endmodule
